// File: src/lzfb_pkg.sv
// Package for the flag-byte LZ decompressor.
// Holds widths, parse phase codes and the window port structs; no dependencies.
package lzfb_pkg;

   localparam int WINDOW_DEPTH     = 4096;
   localparam int WIN_AW           = $clog2(WINDOW_DEPTH);
   localparam int BYTES_PER_RESULT = 8;
   localparam int CNT_W            = $clog2(BYTES_PER_RESULT + 1);
   localparam int LANE_W           = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;
   localparam int OUT_W            = 8 * BYTES_PER_RESULT;
   localparam int LEN_W            = 9;

   localparam logic [LEN_W-1:0] LEN_BIAS_SHORT = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_BIAS_LONG  = LEN_W'(8'h12);

   localparam logic [1:0] PH_FLAG   = 2'd0;
   localparam logic [1:0] PH_TOKEN  = 2'd1;
   localparam logic [1:0] PH_MATCH2 = 2'd2;
   localparam logic [1:0] PH_LEN    = 2'd3;

   typedef logic [WIN_AW-1:0] win_addr_type;

   typedef struct packed {
      logic         en;
      win_addr_type addr;
      logic [7:0]   data;
   } win_wr_type;

   typedef struct packed {
      logic         en;
      win_addr_type addr;
   } win_rd_type;

endpackage

// File: src/lzfb_if.sv
// Valid/ready channel interfaces for the decompressor.
// Depends on lzfb_pkg for payload widths.
interface lzfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_in;
   modport source (output valid, data_byte, last_in, input ready);
   modport sink   (input valid, data_byte, last_in, output ready);
endinterface

interface lzfb_rsp_if;
   import lzfb_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] out_bytes;
   logic [CNT_W-1:0] byte_count;
   logic             done_res;
   logic             status;
   modport source (output valid, out_bytes, byte_count, done_res, status, input ready);
   modport sink   (input valid, out_bytes, byte_count, done_res, status, output ready);
endinterface

interface lzfb_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] output_size;
   modport source (output valid, output_size, input ready);
   modport sink   (input valid, output_size, output ready);
endinterface

// File: src/lzfb_window.sv
// History window: 4096 x 8 synchronous RAM, one write and one read port.
// Read data is registered and holds until the next read. Depends on lzfb_pkg.
module lzfb_window (
   input  logic                 clock,
   input  lzfb_pkg::win_wr_type wr,
   input  lzfb_pkg::win_rd_type rd,
   output logic [7:0]           rdata
);
   import lzfb_pkg::*;

   logic [7:0] mem [WINDOW_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rdata_ff <= mem[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/lz_flag_byte_decompressor.sv
// Flag-byte LZ decompressor top level: parser, match copy sequencer, packer.
// Each copied match byte takes a window read (ST_COPY) and then a window write (ST_PUT),
// and the copy stalls while the result register is full.
// Input bytes are taken only in ST_IDLE, one at a time; window port sets the copy rate.
// Reset: synchronous; afterwards all 4096 window entries are cleared with no
// input taken (register writes still accepted).
module lz_flag_byte_decompressor (
   input  logic       clock,
   input  logic       reset,
   lzfb_req_if.sink   req_ch,
   lzfb_rsp_if.source rsp_ch,
   lzfb_csr_if.sink   csr_ch
);
   import lzfb_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_COPY  = 3'd2;
   localparam logic [2:0] ST_PUT   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [WIN_AW:0]   clr_ff, clr_in;
   logic [31:0]       size_ff, size_in;
   win_addr_type      wp_ff, wp_in;
   logic [31:0]       prod_ff, prod_in;
   logic [7:0]        flag_ff, flag_in;
   logic [3:0]        bits_ff, bits_in;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        tok_ff, tok_in;
   win_addr_type      dist_ff, dist_in;
   logic              fin_ff, fin_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [OUT_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rv_ff, rv_in;
   logic [OUT_W-1:0]  rbytes_ff, rbytes_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;
   logic              rdone_ff, rdone_in;
   logic              rstat_ff, rstat_in;

   win_wr_type        wr;
   win_rd_type        rd;
   logic [7:0]        rdata;
   logic              out_free;
   logic              accept;
   logic              size_hit;
   logic [3:0]        bits_dec;

   lzfb_window u_window (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   assign out_free      = !rv_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign accept        = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;
   assign size_hit      = (prod_ff >= size_ff);
   assign bits_dec      = (bits_ff != 4'd0) ? bits_ff - 4'd1 : 4'd0;

   assign rsp_ch.valid      = rv_ff;
   assign rsp_ch.out_bytes  = rbytes_ff;
   assign rsp_ch.byte_count = rcnt_ff;
   assign rsp_ch.done_res   = rdone_ff;
   assign rsp_ch.status     = rstat_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      size_in   = (csr_ch.valid) ? csr_ch.output_size : size_ff;
      wp_in     = wp_ff;
      prod_in   = prod_ff;
      flag_in   = flag_ff;
      bits_in   = bits_ff;
      phase_in  = phase_ff;
      tok_in    = tok_ff;
      dist_in   = dist_ff;
      fin_in    = fin_ff;
      last_in   = last_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      rv_in     = rv_ff && !rsp_ch.ready;
      rbytes_in = rbytes_ff;
      rcnt_in   = rcnt_ff;
      rdone_in  = rdone_ff;
      rstat_in  = rstat_ff;
      wr.en     = 1'b0;
      wr.addr   = wp_ff;
      wr.data   = req_ch.data_byte;
      rd.en     = 1'b0;
      rd.addr   = wp_ff - dist_ff - win_addr_type'(1);

      case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff[WIN_AW-1:0];
            wr.data = 8'd0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (WIN_AW+1)'(WINDOW_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               last_in = req_ch.last_in;
               acc_in  = '0;
               cnt_in  = '0;
               if (fin_ff) begin
                  if (req_ch.last_in) begin
                     prod_in  = '0;
                     flag_in  = '0;
                     bits_in  = '0;
                     phase_in = PH_FLAG;
                     tok_in   = '0;
                     dist_in  = '0;
                     fin_in   = 1'b0;
                  end
               end else if (size_hit) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_FIN;
                  case (phase_ff)
                     PH_FLAG: begin
                        flag_in  = req_ch.data_byte;
                        bits_in  = 4'd8;
                        phase_in = PH_TOKEN;
                     end
                     PH_TOKEN: begin
                        if (flag_ff[7]) begin
                           // literal: window write and first lane of the packer
                           wr.en    = 1'b1;
                           acc_in   = OUT_W'(req_ch.data_byte);
                           cnt_in   = CNT_W'(1);
                           wp_in    = wp_ff + win_addr_type'(1);
                           prod_in  = prod_ff + 32'd1;
                           flag_in  = {flag_ff[6:0], 1'b0};
                           bits_in  = bits_dec;
                           phase_in = (bits_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                        end else begin
                           tok_in   = req_ch.data_byte;
                           phase_in = PH_MATCH2;
                        end
                     end
                     PH_MATCH2: begin
                        dist_in = {tok_ff[3:0], req_ch.data_byte};
                        if (tok_ff[7:4] != 4'd0) begin
                           len_in   = LEN_W'(tok_ff[7:4]) + LEN_BIAS_SHORT;
                           state_in = ST_COPY;
                        end else begin
                           phase_in = PH_LEN;
                        end
                     end
                     default: begin
                        len_in   = LEN_W'(req_ch.data_byte) + LEN_BIAS_LONG;
                        state_in = ST_COPY;
                     end
                  endcase
               end
            end
         end
         ST_COPY: begin
            if (len_ff == '0 || size_hit) begin
               flag_in  = {flag_ff[6:0], 1'b0};
               bits_in  = bits_dec;
               phase_in = (bits_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
               state_in = ST_FIN;
            end else begin
               rd.en    = 1'b1;
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            // packer full: hand the eight bytes to the result register first
            if (cnt_ff != CNT_W'(BYTES_PER_RESULT) || out_free) begin
               wr.en   = 1'b1;
               wr.data = rdata;
               wp_in   = wp_ff + win_addr_type'(1);
               prod_in = prod_ff + 32'd1;
               len_in  = len_ff - LEN_W'(1);
               if (cnt_ff == CNT_W'(BYTES_PER_RESULT)) begin
                  rv_in     = 1'b1;
                  rbytes_in = acc_ff;
                  rcnt_in   = cnt_ff;
                  rdone_in  = 1'b0;
                  rstat_in  = 1'b0;
                  acc_in    = OUT_W'(rdata);
                  cnt_in    = CNT_W'(1);
               end else begin
                  acc_in = acc_ff | (OUT_W'(rdata) << {cnt_ff[LANE_W-1:0], 3'b000});
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               state_in = ST_COPY;
            end
         end
         ST_FIN: begin
            if (size_hit || last_ff || cnt_ff != '0) begin
               if (out_free) begin
                  rv_in     = 1'b1;
                  rbytes_in = acc_ff;
                  rcnt_in   = cnt_ff;
                  rdone_in  = size_hit || last_ff;
                  rstat_in  = !size_hit && last_ff;
                  acc_in    = '0;
                  cnt_in    = '0;
                  state_in  = ST_IDLE;
                  if (size_hit) begin
                     fin_in = 1'b1;
                  end
                  if (last_ff) begin
                     prod_in  = '0;
                     flag_in  = '0;
                     bits_in  = '0;
                     phase_in = PH_FLAG;
                     tok_in   = '0;
                     dist_in  = '0;
                     fin_in   = 1'b0;
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         size_ff  <= '0;
         wp_ff    <= '0;
         prod_ff  <= '0;
         flag_ff  <= '0;
         bits_ff  <= '0;
         phase_ff <= PH_FLAG;
         tok_ff   <= '0;
         dist_ff  <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         size_ff  <= size_in;
         wp_ff    <= wp_in;
         prod_ff  <= prod_in;
         flag_ff  <= flag_in;
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
         tok_ff   <= tok_in;
         dist_ff  <= dist_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      rbytes_ff <= rbytes_in;
      rcnt_ff   <= rcnt_in;
      rdone_ff  <= rdone_in;
      rstat_ff  <= rstat_in;
   end

`ifndef NO_ASSERTIONS
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("input taken during window clear");

   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BYTES_PER_RESULT))
      else $error("packer overflow");

   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rstat_ff) |-> rdone_ff)
      else $error("truncated status without done");

   a_put_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |-> $past(state_ff) == ST_COPY || $past(state_ff) == ST_PUT)
      else $error("window data used without a read");
`endif

endmodule
